[rtl/core/cssp_pkg.sv]
// ----------------------------------------------------------------------------
// cssp_pkg
// Shared types, widths and constants for the serially programmed clock
// synthesizer entry table and its frequency pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cssp_pkg;

  // Table and serial word geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int WORD_BITS     = 20;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(WORD_BITS + 1);
  localparam int LOC_W         = 5;
  localparam int NCODE_W       = 8;
  localparam int DCODE_W       = 2;

  // Field widths
  localparam int REF_W   = 26;
  localparam int FREQ_W  = 30;
  localparam int N_W     = 10;
  localparam int DIV_W   = 4;
  localparam int SEL_W   = 4;

  // Stream widths
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 48;

  // Reference reset value and feedback offset
  localparam logic [REF_W-1:0] REF_RESET = REF_W'(14318182);
  localparam logic [N_W-1:0]   N_BASE    = N_W'(257);

  // Fixed prescaler of the synthesizer and its reciprocals
  localparam int PRESCALE   = 46;
  localparam int QUOT_W     = 21;          // ref / 46 fits below 2^21
  localparam int REM_W      = 6;           // remainder 0..45
  localparam int REM0_W     = 7;           // uncorrected remainder 0..91
  localparam int REF_RCP_W  = 27;
  localparam int REF_RCP_SH = 32;
  localparam logic [REF_RCP_W-1:0] REF_RCP = REF_RCP_W'(93368854);  // floor(2^32/46)

  localparam int AN_W       = QUOT_W + N_W;   // quotient times N
  localparam int BN_W       = REM_W + N_W - 1; // remainder times N, below 2^15
  localparam int BQ_W       = 10;
  localparam int BN_RCP_W   = 19;
  localparam int BN_RCP_SH  = 24;
  localparam logic [BN_RCP_W-1:0] BN_RCP = BN_RCP_W'(364723);      // ceil(2^24/46)

  // Output queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

  // Stored part of one table entry
  typedef struct packed {
    logic [DCODE_W-1:0] dcode;
    logic [NCODE_W-1:0] ncode;
  } cssp_entry_t;

  // One result beat
  typedef struct packed {
    logic [DIV_W-1:0]  post_divider;
    logic [N_W-1:0]    n_value;
    logic [FREQ_W-1:0] freq_hz;
  } cssp_result_t;

  // Post-divider value for a divider code
  function automatic logic [DIV_W-1:0] div_of_code(input logic [DCODE_W-1:0] code);
    logic [DIV_W-1:0] d;
    unique case (code)
      2'd0:    d = DIV_W'(8);
      2'd1:    d = DIV_W'(4);
      2'd2:    d = DIV_W'(2);
      default: d = DIV_W'(1);
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cssp_freq_pipe.sv]
// ----------------------------------------------------------------------------
// cssp_freq_pipe
// Turns a selected table entry into frequency, N and divider. The reference
// arrives split as ref = 46*quot + rem, so floor(ref*N/46) is quot*N plus
// floor(rem*N/46); the post-divider is a right shift at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module cssp_freq_pipe (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_entry_valid,
  input  cssp_pkg::cssp_entry_t          in_entry,
  input  logic [cssp_pkg::QUOT_W-1:0]    ref_quot,
  input  logic [cssp_pkg::REM_W-1:0]     ref_rem,
  output logic                           out_valid,
  output cssp_pkg::cssp_result_t         out_result
);
  import cssp_pkg::*;

  logic [N_W-1:0]   n_eff;
  logic [DIV_W-1:0] d_eff;

  // Stage 2 registers
  logic               s2_valid;
  logic [AN_W-1:0]    s2_an;
  logic [BN_W-1:0]    s2_bn;
  logic [DCODE_W-1:0] s2_dsh;
  logic [N_W-1:0]     s2_n;
  logic [DIV_W-1:0]   s2_d;

  // Stage 3 registers
  logic               s3_valid;
  logic [AN_W-1:0]    s3_an;
  logic [BQ_W-1:0]    s3_bq;
  logic [DCODE_W-1:0] s3_dsh;
  logic [N_W-1:0]     s3_n;
  logic [DIV_W-1:0]   s3_d;

  logic [BN_W+BN_RCP_W-1:0] bq_prod;
  logic [AN_W:0]            sum;

  // Unprogrammed entries report zero everywhere: N of zero zeroes the products
  assign n_eff = in_entry_valid ? (N_W'(in_entry.ncode) + N_BASE) : '0;
  assign d_eff = in_entry_valid ? div_of_code(in_entry.dcode) : '0;

  // Multiply both parts of the reference by N; skip the shift for empty entries
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
    end
    s2_an  <= AN_W'(ref_quot) * AN_W'(n_eff);
    s2_bn  <= BN_W'(BN_W'(ref_rem) * BN_W'(n_eff));
    s2_dsh <= in_entry_valid ? ~in_entry.dcode : '0;
    s2_n   <= n_eff;
    s2_d   <= d_eff;
  end

  // Divide the remainder product by 46 through its reciprocal
  assign bq_prod = (BN_W+BN_RCP_W)'(s2_bn) * (BN_W+BN_RCP_W)'(BN_RCP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_an  <= s2_an;
    s3_bq  <= bq_prod[BN_RCP_SH +: BQ_W];
    s3_dsh <= s2_dsh;
    s3_n   <= s2_n;
    s3_d   <= s2_d;
  end

  // Add the two parts and apply the post-divider
  assign sum = (AN_W+1)'(s3_an) + (AN_W+1)'(s3_bq);

  assign out_valid               = s3_valid;
  assign out_result.freq_hz      = FREQ_W'(sum >> s3_dsh);
  assign out_result.n_value      = s3_n;
  assign out_result.post_divider = s3_d;

endmodule

`default_nettype wire

[rtl/core/clock_synth_serial_program.sv]
// ----------------------------------------------------------------------------
// clock_synth_serial_program
// Serially programmed PLL synthesizer entry table with frequency readout.
// ----------------------------------------------------------------------------
// One input beat is taken per clock unless input is held off, and each gives one
// result beat. The serial shift state updates on the accepting edge; the
// 16-entry table is a synchronous memory read on that same edge, with a write
// of the same entry on that edge forwarded to the read. The frequency then
// passes through two multiplies and a final add and shift, and an 8-deep
// output queue lets input keep flowing while results wait. After reset and
// after every write of ref_freq_hz the input is held off while ref_freq_hz is
// split into ref/46 and its remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_synth_serial_program (
  input  logic                              clk,
  input  logic                              rst,
  // ref_freq_hz register write
  input  logic                              cfg_wr_en,
  input  logic [cssp_pkg::REF_W-1:0]        cfg_wr_data,
  // input beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cssp_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [3:0] sel_bits
  input  logic                              s_axis_tuser,  // [0] strobe_req
  // result beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cssp_pkg::M_TDATA_W-1:0]    m_axis_tdata   // [29:0] freq_hz,
                                                           // [39:30] n_value,
                                                           // [43:40] post_divider
);
  import cssp_pkg::*;

  // Handshakes
  logic in_acc;
  logic out_acc;

  // Input fields
  logic               strobe;
  logic [SEL_W-1:0]   sel;
  logic               dclk;
  logic               ddat;

  // Serial state
  logic                 prev_dclk, prev_dclk_next;
  logic                 writing, writing_next;
  logic [WORD_BITS-1:0] shift_word, shift_word_next;
  logic [CNT_W-1:0]     bit_cnt, bit_cnt_next;
  logic                 commit;

  // Commit fields
  logic [LOC_W-1:0]   loc;
  logic               loc_ok;
  logic               tbl_wr;
  logic [TBL_AW-1:0]  wr_idx;
  cssp_entry_t        wr_entry;
  logic [TBL_AW-1:0]  rd_idx;
  logic               sel_ok;

  // Entry table
  cssp_entry_t              ent_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] ent_valid;

  // Stage 1
  logic        p1_valid;
  logic        p1_hit_valid;
  logic        p1_fwd;
  cssp_entry_t p1_fwd_entry;
  cssp_entry_t mem_q;
  cssp_entry_t p1_entry;

  // Reference split
  logic [REF_W-1:0]           ref_freq;
  logic [1:0]                 ref_busy;
  logic [REF_W+REF_RCP_W-1:0] ref_prod;
  logic [QUOT_W-1:0]          ref_q0;
  logic [REM0_W-1:0]          ref_r0;
  logic [QUOT_W-1:0]          ref_quot;
  logic [REM_W-1:0]           ref_rem;

  // Pipeline output and result queue
  logic           pipe_valid;
  cssp_result_t   pipe_result;
  cssp_result_t   fifo_mem [OUT_DEPTH];
  logic [OUT_AW-1:0] fifo_wr_ptr;
  logic [OUT_AW-1:0] fifo_rd_ptr;
  logic [OCC_W-1:0]  fifo_cnt;
  logic [OCC_W-1:0]  occ;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign strobe = s_axis_tuser;
  assign sel    = s_axis_tdata[SEL_W-1:0];
  assign dclk   = sel[3];
  assign ddat   = sel[2];

  // Advance the serial receiver on a strobed rising data clock
  always_comb begin
    prev_dclk_next  = prev_dclk;
    writing_next    = writing;
    shift_word_next = shift_word;
    bit_cnt_next    = bit_cnt;
    commit          = 1'b0;
    if (strobe) begin
      prev_dclk_next = dclk;
      if (dclk && !prev_dclk) begin
        if (!writing) begin
          writing_next = ddat;
          bit_cnt_next = '0;
        end else begin
          shift_word_next = {ddat, shift_word[WORD_BITS-1:1]};
          if (bit_cnt == CNT_W'(WORD_BITS - 1)) begin
            commit       = 1'b1;
            writing_next = 1'b0;
            bit_cnt_next = '0;
          end else begin
            bit_cnt_next = bit_cnt + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_dclk  <= 1'b0;
      writing    <= 1'b0;
      shift_word <= '0;
      bit_cnt    <= '0;
    end else if (in_acc) begin
      prev_dclk  <= prev_dclk_next;
      writing    <= writing_next;
      shift_word <= shift_word_next;
      bit_cnt    <= bit_cnt_next;
    end
  end

  // Decode the completed word; drop locations past the table
  assign loc            = shift_word_next[6:2];
  assign wr_entry.ncode = shift_word_next[14:7];
  assign wr_entry.dcode = shift_word_next[17:16];
  assign loc_ok         = 32'(loc) < TABLE_ENTRIES;
  assign wr_idx         = loc[TBL_AW-1:0];
  assign tbl_wr         = in_acc && commit && loc_ok;

  assign rd_idx = sel[TBL_AW-1:0];
  assign sel_ok = 32'(sel) < TABLE_ENTRIES;

  // Table memory: write the committed entry, read the selected one
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      ent_mem[wr_idx] <= wr_entry;
    end
    if (in_acc) begin
      mem_q <= ent_mem[rd_idx];
    end
  end

  // Programmed flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (tbl_wr) begin
      ent_valid[wr_idx] <= 1'b1;
    end
  end

  // Stage 1: forward a same-edge write of the selected entry
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= in_acc;
    end
    if (in_acc) begin
      p1_fwd       <= tbl_wr && (wr_idx == rd_idx);
      p1_fwd_entry <= wr_entry;
      p1_hit_valid <= sel_ok && (ent_valid[rd_idx] || (tbl_wr && (wr_idx == rd_idx)));
    end
  end

  assign p1_entry = p1_fwd ? p1_fwd_entry : mem_q;

  // Reference register and hold-off while it is split
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_freq <= REF_RESET;
      ref_busy <= 2'd2;
    end else if (cfg_wr_en) begin
      ref_freq <= cfg_wr_data;
      ref_busy <= 2'd2;
    end else if (ref_busy != 2'd0) begin
      ref_busy <= ref_busy - 2'd1;
    end
  end

  // Split ref into ref/46 and remainder: reciprocal estimate, then correct
  assign ref_prod = (REF_W+REF_RCP_W)'(ref_freq) * (REF_W+REF_RCP_W)'(REF_RCP);
  assign ref_r0   = REM0_W'(ref_freq - REF_W'(REF_W'(ref_q0) * REF_W'(PRESCALE)));

  always_ff @(posedge clk) begin
    ref_q0 <= ref_prod[REF_RCP_SH +: QUOT_W];
    if (ref_r0 >= REM0_W'(PRESCALE)) begin
      ref_quot <= ref_q0 + 1'b1;
      ref_rem  <= REM_W'(ref_r0 - REM0_W'(PRESCALE));
    end else begin
      ref_quot <= ref_q0;
      ref_rem  <= REM_W'(ref_r0);
    end
  end

  cssp_freq_pipe u_freq_pipe (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (p1_valid),
    .in_entry_valid (p1_hit_valid),
    .in_entry       (p1_entry),
    .ref_quot       (ref_quot),
    .ref_rem        (ref_rem),
    .out_valid      (pipe_valid),
    .out_result     (pipe_result)
  );

  // Result queue
  always_ff @(posedge clk) begin
    if (pipe_valid) begin
      fifo_mem[fifo_wr_ptr] <= pipe_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wr_ptr <= '0;
      fifo_rd_ptr <= '0;
      fifo_cnt    <= '0;
    end else begin
      if (pipe_valid) begin
        fifo_wr_ptr <= fifo_wr_ptr + 1'b1;
      end
      if (out_acc) begin
        fifo_rd_ptr <= fifo_rd_ptr + 1'b1;
      end
      unique case ({pipe_valid, out_acc})
        2'b10:   fifo_cnt <= fifo_cnt + 1'b1;
        2'b01:   fifo_cnt <= fifo_cnt - 1'b1;
        default: fifo_cnt <= fifo_cnt;
      endcase
    end
  end

  // Count beats taken but not yet delivered; it bounds the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      unique case ({in_acc, out_acc})
        2'b10:   occ <= occ + 1'b1;
        2'b01:   occ <= occ - 1'b1;
        default: occ <= occ;
      endcase
    end
  end

  assign s_axis_tready = (ref_busy == 2'd0) && (occ < OCC_W'(OUT_DEPTH));
  assign m_axis_tvalid = fifo_cnt != '0;
  assign m_axis_tdata  = M_TDATA_W'(fifo_mem[fifo_rd_ptr]);

  // Queued results never outnumber outstanding beats
  a_fifo_within_occ: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= occ)
    else $error("result queue holds more beats than are outstanding");

  // A result leaving the pipeline always has a free queue slot
  a_fifo_room: assert property (@(posedge clk) disable iff (rst)
    pipe_valid |-> (fifo_cnt < occ))
    else $error("result written with no outstanding beat or full queue");

  // Input is held off right after a reference write
  a_ref_holdoff: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> !s_axis_tready)
    else $error("input accepted while reference split is stale");

endmodule

`default_nettype wire
